/* design/lac_pkg.sv */
// shared types and constants for the letterbox alpha compositor
// no dependencies; used by every module of the block
package lac_pkg;

  localparam int MAX_DIM_DEF = 4096;
  localparam int CFG_DIM_W   = 13;
  localparam int CFG_RGB_W   = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int CHAN_W      = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_DIM_W-1:0] DIM_RESET = CFG_DIM_W'(800);
  localparam logic [CFG_RGB_W-1:0] RGB_RESET = 24'hFFFFFF;
  localparam logic [CHAN_W-1:0]    OPAQUE    = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_WIDTH   = 3'd0,
    REG_TARGET_HEIGHT  = 3'd1,
    REG_CONTENT_WIDTH  = 3'd2,
    REG_CONTENT_HEIGHT = 3'd3,
    REG_BACKGROUND_RGB = 3'd4,
    REG_ALPHA_ENABLE   = 3'd5
  } lac_reg_t;

  // what the back end does with a queued word
  typedef enum logic [1:0] {
    OP_BACKGROUND,
    OP_BLEND,
    OP_COPY,
    OP_PASS
  } lac_op_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] target_width;
    logic [CFG_DIM_W-1:0] target_height;
    logic [CFG_DIM_W-1:0] content_width;
    logic [CFG_DIM_W-1:0] content_height;
    logic                 alpha_enable;
  } lac_cfg_t;

  typedef struct packed {
    lac_op_t           op;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              row_end;
    logic              frame_end;
  } lac_item_t;

endpackage

/* design/letterbox_alpha_compositor_top.sv */
// top level of the letterbox alpha compositor: config registers and wiring
// depends on lac_pkg, lac_front, lac_queue and lac_back
//
// usage
// - one input word is one output raster tick carrying the content pixel that
//   upstream currently offers; one output word comes back per input word
// - content is centred in the target frame; ticks outside the window give the
//   background colour, ticks inside give the content blended over it (or
//   copied when alpha is off) and set consumed so upstream can advance
// - when the content is at least the target size both ways, pixels pass
//   through unchanged with their alpha and the raster follows the content size
// - one word per clock while out_ready stays high; from input accept to output
//   valid a word passes queue write, multiply stage, then divide into the output
// - a four-word queue decouples the raster counters from the blend pipe, so
//   input ready depends only on queue fill, never directly on output ready
// - when the receiver stalls the output word holds and the pipe freezes; the
//   queue keeps taking input until it is full
// - config writes are always ready and must only be made while idle
// - reset puts the registers at their defaults and the raster at its origin;
//   no clearing pass, the block is ready the cycle after reset is released
module letterbox_alpha_compositor_top #(
  parameter int MAX_DIM = lac_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lac_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lac_pkg::CHAN_W-1:0]     in_pixel_red,
  input  logic [lac_pkg::CHAN_W-1:0]     in_pixel_green,
  input  logic [lac_pkg::CHAN_W-1:0]     in_pixel_blue,
  input  logic [lac_pkg::CHAN_W-1:0]     in_pixel_alpha,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lac_pkg::CHAN_W-1:0]     out_red,
  output logic [lac_pkg::CHAN_W-1:0]     out_green,
  output logic [lac_pkg::CHAN_W-1:0]     out_blue,
  output logic [lac_pkg::CHAN_W-1:0]     out_alpha,
  output logic                          out_consumed,
  output logic                          out_row_end,
  output logic                          out_frame_end
);

  lac_pkg::lac_cfg_t               cfg_r;
  logic [lac_pkg::CFG_RGB_W-1:0]   background_rgb_r;
  lac_pkg::lac_item_t              front_item, back_item;
  logic                            in_accept;
  logic                            q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  // config register file, one register per index, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_width   <= lac_pkg::DIM_RESET;
      cfg_r.target_height  <= lac_pkg::DIM_RESET;
      cfg_r.content_width  <= lac_pkg::DIM_RESET;
      cfg_r.content_height <= lac_pkg::DIM_RESET;
      cfg_r.alpha_enable   <= 1'b1;
      background_rgb_r     <= lac_pkg::RGB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (lac_pkg::lac_reg_t'(cfg_index))
        lac_pkg::REG_TARGET_WIDTH: begin
          cfg_r.target_width <= cfg_data[lac_pkg::CFG_DIM_W-1:0];
        end
        lac_pkg::REG_TARGET_HEIGHT: begin
          cfg_r.target_height <= cfg_data[lac_pkg::CFG_DIM_W-1:0];
        end
        lac_pkg::REG_CONTENT_WIDTH: begin
          cfg_r.content_width <= cfg_data[lac_pkg::CFG_DIM_W-1:0];
        end
        lac_pkg::REG_CONTENT_HEIGHT: begin
          cfg_r.content_height <= cfg_data[lac_pkg::CFG_DIM_W-1:0];
        end
        lac_pkg::REG_BACKGROUND_RGB: begin
          background_rgb_r <= cfg_data[lac_pkg::CFG_RGB_W-1:0];
        end
        lac_pkg::REG_ALPHA_ENABLE: begin
          cfg_r.alpha_enable <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // raster walk and classification of each tick
  lac_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (in_accept),
    .pixel_red   (in_pixel_red),
    .pixel_green (in_pixel_green),
    .pixel_blue  (in_pixel_blue),
    .pixel_alpha (in_pixel_alpha),
    .item        (front_item)
  );

  lac_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_item (front_item),
    .pop       (q_pop),
    .pop_item  (back_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  // blend pipe and output register
  lac_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .background_rgb (background_rgb_r),
    .item           (back_item),
    .item_avail     (!q_empty),
    .item_take      (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_consumed   (out_consumed),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end)
  );

`ifndef ASSERT_OFF
  a_frame_end_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> out_row_end)
    else $error("frame end without row end");
  a_background_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_consumed) |-> out_alpha == lac_pkg::OPAQUE)
    else $error("background word not opaque");
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back end took a word from an empty queue");
`endif

endmodule

/* design/lac_front.sv */
// front end: raster position counters and per-tick window classification
// depends on lac_pkg for the config and queue word types
module lac_front #(
  parameter int MAX_DIM = lac_pkg::MAX_DIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lac_pkg::lac_cfg_t           cfg,
  input  logic                        accept,
  input  logic [lac_pkg::CHAN_W-1:0]  pixel_red,
  input  logic [lac_pkg::CHAN_W-1:0]  pixel_green,
  input  logic [lac_pkg::CHAN_W-1:0]  pixel_blue,
  input  logic [lac_pkg::CHAN_W-1:0]  pixel_alpha,
  output lac_pkg::lac_item_t          item
);

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int DW    = DIM_W + 1;
  localparam int EW    = (DW > lac_pkg::CFG_DIM_W) ? DW : lac_pkg::CFG_DIM_W;

  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;

  logic [DW-1:0] tw, th, cw, ch, ww, wh, dj, di, rw, rh, col_x, row_x;
  logic          pad, in_win, rend, fend;

  // zero reads as one, anything past the limit as the limit
  function automatic logic [DW-1:0] clamp_dim(input logic [lac_pkg::CFG_DIM_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (v == '0) return DW'(1);
    else if (ve > EW'(MAX_DIM)) return DW'(MAX_DIM);
    else return DW'(ve);
  endfunction

  always_comb begin
    tw    = clamp_dim(cfg.target_width);
    th    = clamp_dim(cfg.target_height);
    cw    = clamp_dim(cfg.content_width);
    ch    = clamp_dim(cfg.content_height);
    col_x = {1'b0, col_r};
    row_x = {1'b0, row_r};
    pad   = (cw < tw) || (ch < th);
    ww    = (cw < tw) ? cw : tw;
    wh    = (ch < th) ? ch : th;
    dj    = (tw - ww) >> 1;
    di    = (th - wh) >> 1;
    in_win = (row_x >= di) && ((row_x - di) < wh) &&
             (col_x >= dj) && ((col_x - dj) < ww);
    rw    = pad ? tw : cw;
    rh    = pad ? th : ch;
    rend  = col_x >= (rw - DW'(1));
    fend  = rend && (row_x >= (rh - DW'(1)));

    item.red       = pixel_red;
    item.green     = pixel_green;
    item.blue      = pixel_blue;
    item.alpha     = pixel_alpha;
    item.row_end   = rend;
    item.frame_end = fend;
    if (!pad) begin
      item.op = lac_pkg::OP_PASS;
    end else if (!in_win) begin
      item.op = lac_pkg::OP_BACKGROUND;
    end else if (cfg.alpha_enable) begin
      item.op = lac_pkg::OP_BLEND;
    end else begin
      item.op = lac_pkg::OP_COPY;
    end

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (rend) begin
        col_nxt = '0;
        row_nxt = fend ? '0 : DIM_W'(row_x + DW'(1));
      end else begin
        col_nxt = DIM_W'(col_x + DW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* design/lac_queue.sv */
// short first-in first-out queue of classified words between front and back
// depends on lac_pkg for the word type and depth
module lac_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lac_pkg::lac_item_t push_item,
  input  logic               pop,
  output lac_pkg::lac_item_t pop_item,
  output logic               full,
  output logic               empty
);

  localparam int PTR_W = $clog2(lac_pkg::QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  lac_pkg::lac_item_t mem_r [lac_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full     = count_r == CNT_W'(lac_pkg::QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(lac_pkg::QUEUE_DEPTH))
    else $error("queue count past depth");
  a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    PTR_W'(wr_ptr_r - rd_ptr_r) == PTR_W'(count_r))
    else $error("queue pointers disagree with count");
  a_push_only_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count did not grow on push");
`endif

endmodule

/* design/lac_back.sv */
// back end: two-stage blend pipeline with registered output word
// depends on lac_pkg for the queue word type and op codes
module lac_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lac_pkg::CFG_RGB_W-1:0] background_rgb,
  input  lac_pkg::lac_item_t           item,
  input  logic                         item_avail,
  output logic                         item_take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lac_pkg::CHAN_W-1:0]   out_red,
  output logic [lac_pkg::CHAN_W-1:0]   out_green,
  output logic [lac_pkg::CHAN_W-1:0]   out_blue,
  output logic [lac_pkg::CHAN_W-1:0]   out_alpha,
  output logic                         out_consumed,
  output logic                         out_row_end,
  output logic                         out_frame_end
);

  localparam int SUM_W = 2 * lac_pkg::CHAN_W;

  logic                       adv;
  logic [lac_pkg::CHAN_W-1:0] fg [3];
  logic [lac_pkg::CHAN_W-1:0] bg [3];
  logic [lac_pkg::CHAN_W-1:0] mix_a;
  logic [SUM_W-1:0]           sum_nxt [3];
  logic [SUM_W-1:0]           sum_r [3];
  logic [SUM_W-1:0]           fix [3];
  logic                       s1_valid_r;
  logic [lac_pkg::CHAN_W-1:0] s1_alpha_r;
  logic                       s1_consumed_r, s1_row_end_r, s1_frame_end_r;
  logic                       out_valid_r;
  logic [lac_pkg::CHAN_W-1:0] out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic                       out_consumed_r, out_row_end_r, out_frame_end_r;

  // whole pipe moves together whenever the output slot is free
  assign adv       = !out_valid_r || out_ready;
  assign item_take = item_avail && adv;

  always_comb begin
    bg[0] = background_rgb[23:16];
    bg[1] = background_rgb[15:8];
    bg[2] = background_rgb[7:0];
    // background goes through the same path as colour times full alpha
    if (item.op == lac_pkg::OP_BACKGROUND) begin
      fg[0] = bg[0];
      fg[1] = bg[1];
      fg[2] = bg[2];
    end else begin
      fg[0] = item.red;
      fg[1] = item.green;
      fg[2] = item.blue;
    end
    mix_a = (item.op == lac_pkg::OP_BLEND) ? item.alpha : lac_pkg::OPAQUE;
    for (int c = 0; c < 3; c++) begin
      sum_nxt[c] = SUM_W'(fg[c]) * SUM_W'(mix_a) +
                   SUM_W'(bg[c]) * SUM_W'(lac_pkg::OPAQUE - mix_a);
      // exact divide by 255 for sums below 255 * 256
      fix[c] = sum_r[c] + SUM_W'(1) + SUM_W'(sum_r[c][SUM_W-1:lac_pkg::CHAN_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= item_take;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) sum_r[c] <= sum_nxt[c];
      s1_alpha_r     <= (item.op == lac_pkg::OP_PASS) ? item.alpha : lac_pkg::OPAQUE;
      s1_consumed_r  <= item.op != lac_pkg::OP_BACKGROUND;
      s1_row_end_r   <= item.row_end;
      s1_frame_end_r <= item.frame_end;

      out_red_r       <= fix[0][SUM_W-1:lac_pkg::CHAN_W];
      out_green_r     <= fix[1][SUM_W-1:lac_pkg::CHAN_W];
      out_blue_r      <= fix[2][SUM_W-1:lac_pkg::CHAN_W];
      out_alpha_r     <= s1_alpha_r;
      out_consumed_r  <= s1_consumed_r;
      out_row_end_r   <= s1_row_end_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_alpha     = out_alpha_r;
  assign out_consumed  = out_consumed_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

/* test/lac_tick_check_pkg.sv */
`timescale 1ns / 100ps
// raster predictor and word queue for the letterbox alpha compositor test
// depends on lac_pkg from the design for widths, register codes and resets
package lac_tick_check_pkg;
  import lac_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              consumed;
    logic              row_end;
    logic              frame_end;
  } tick_word_t;

  class composite_scoreboard;
    bit [CFG_DIM_W-1:0] target_width;
    bit [CFG_DIM_W-1:0] target_height;
    bit [CFG_DIM_W-1:0] content_width;
    bit [CFG_DIM_W-1:0] content_height;
    bit [CFG_RGB_W-1:0] background_rgb;
    bit                 alpha_enable;
    bit [11:0]          row_pos;
    bit [11:0]          col_pos;
    tick_word_t         ticks_due[$];
    int                 words_in;
    int                 words_out;
    int                 fail_count;

    function new();
      target_width   = DIM_RESET;
      target_height  = DIM_RESET;
      content_width  = DIM_RESET;
      content_height = DIM_RESET;
      background_rgb = RGB_RESET;
      alpha_enable   = 1'b1;
      row_pos        = '0;
      col_pos        = '0;
      words_in       = 0;
      words_out      = 0;
      fail_count     = 0;
    endfunction

    function void write_register(bit [CFG_IDX_W-1:0] index, bit [CFG_DATA_W-1:0] data);
      case (index)
        REG_TARGET_WIDTH:   target_width   = data[CFG_DIM_W-1:0];
        REG_TARGET_HEIGHT:  target_height  = data[CFG_DIM_W-1:0];
        REG_CONTENT_WIDTH:  content_width  = data[CFG_DIM_W-1:0];
        REG_CONTENT_HEIGHT: content_height = data[CFG_DIM_W-1:0];
        REG_BACKGROUND_RGB: background_rgb = data[CFG_RGB_W-1:0];
        REG_ALPHA_ENABLE:   alpha_enable   = data[0];
        default: ;
      endcase
    endfunction

    // zero reads as one, oversize as the largest frame
    function int unsigned fit_dim(bit [CFG_DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return v;
    endfunction

    function bit [CHAN_W-1:0] blend_channel(bit [CHAN_W-1:0] fg, bit [CHAN_W-1:0] bg,
                                            bit [CHAN_W-1:0] a);
      int unsigned mix;
      mix = fg * a + bg * (255 - a);
      return CHAN_W'(mix / 255);
    endfunction

    // one accepted input word: predict its output word and step the raster
    function void note_tick(bit [CHAN_W-1:0] red, bit [CHAN_W-1:0] green,
                            bit [CHAN_W-1:0] blue, bit [CHAN_W-1:0] alpha);
      int unsigned tw, th, cw, ch, win_w, win_h, off_x, off_y, span_w, span_h;
      bit          letterbox, in_window;
      bit [CHAN_W-1:0] bg_r, bg_g, bg_b;
      tick_word_t  want;
      tw = fit_dim(target_width);
      th = fit_dim(target_height);
      cw = fit_dim(content_width);
      ch = fit_dim(content_height);
      bg_r = background_rgb[23:16];
      bg_g = background_rgb[15:8];
      bg_b = background_rgb[7:0];
      letterbox = (cw < tw) || (ch < th);
      want = '0;
      if (letterbox) begin
        win_w  = (cw < tw) ? cw : tw;
        win_h  = (ch < th) ? ch : th;
        off_x  = (tw - win_w) / 2;
        off_y  = (th - win_h) / 2;
        in_window = (row_pos >= off_y) && (row_pos - off_y < win_h) &&
                    (col_pos >= off_x) && (col_pos - off_x < win_w);
        span_w = tw;
        span_h = th;
        want.alpha = OPAQUE;
        if (in_window) begin
          want.consumed = 1'b1;
          if (alpha_enable) begin
            want.red   = blend_channel(red, bg_r, alpha);
            want.green = blend_channel(green, bg_g, alpha);
            want.blue  = blend_channel(blue, bg_b, alpha);
          end else begin
            want.red   = red;
            want.green = green;
            want.blue  = blue;
          end
        end else begin
          want.red   = bg_r;
          want.green = bg_g;
          want.blue  = bg_b;
        end
      end else begin
        span_w = cw;
        span_h = ch;
        want.red      = red;
        want.green    = green;
        want.blue     = blue;
        want.alpha    = alpha;
        want.consumed = 1'b1;
      end
      if (col_pos >= span_w - 1) begin
        want.row_end = 1'b1;
        col_pos = '0;
        if (row_pos >= span_h - 1) begin
          want.frame_end = 1'b1;
          row_pos = '0;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
      ticks_due.push_back(want);
      words_in++;
    endfunction

    task report_mismatch(string what);
      fail_count++;
      $display("mismatch: %s", what);
    endtask

    task compare_field(string name, logic [CHAN_W-1:0] got, logic [CHAN_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("word %0d %s got %0h want %0h", words_out, name, got, want));
    endtask

    task check_tick(tick_word_t got);
      tick_word_t want;
      if (ticks_due.size() == 0) begin
        report_mismatch($sformatf("word %0d came out with none predicted", words_out));
        words_out++;
        return;
      end
      want = ticks_due.pop_front();
      compare_field("red", got.red, want.red);
      compare_field("green", got.green, want.green);
      compare_field("blue", got.blue, want.blue);
      compare_field("alpha", got.alpha, want.alpha);
      compare_field("consumed", CHAN_W'(got.consumed), CHAN_W'(want.consumed));
      compare_field("row_end", CHAN_W'(got.row_end), CHAN_W'(want.row_end));
      compare_field("frame_end", CHAN_W'(got.frame_end), CHAN_W'(want.frame_end));
      words_out++;
    endtask

    function int pending();
      return ticks_due.size();
    endfunction

    task flag_leftovers();
      if (ticks_due.size() != 0)
        report_mismatch($sformatf("%0d predicted words never came out", ticks_due.size()));
    endtask
  endclass

endpackage

/* test/letterbox_alpha_compositor_top_test.sv */
`timescale 1ns / 100ps
// self-checking test of letterbox_alpha_compositor_top: directed corners, then
// random settings and pixels with random idling; needs lac_pkg, lac_tick_check_pkg
module letterbox_alpha_compositor_top_test;
  import lac_pkg::*;
  import lac_tick_check_pkg::*;

  // handshake-free cycles before the run is declared hung
  localparam int IDLE_LIMIT       = 2000;
  // one long receiver hold-off, started once this many words have gone in
  localparam int LONG_HOLD        = 120;
  localparam int HOLD_AFTER_WORDS = 250;
  localparam int RANDOM_PHASES    = 8;
  localparam int WORDS_PER_PHASE  = 50;
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [CFG_DATA_W-1:0] target_width;
    logic [CFG_DATA_W-1:0] target_height;
    logic [CFG_DATA_W-1:0] content_width;
    logic [CFG_DATA_W-1:0] content_height;
    logic [CFG_DATA_W-1:0] background_rgb;
    logic                  alpha_enable;
  } reg_setting_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [CHAN_W-1:0]     in_pixel_red;
  logic [CHAN_W-1:0]     in_pixel_green;
  logic [CHAN_W-1:0]     in_pixel_blue;
  logic [CHAN_W-1:0]     in_pixel_alpha;
  logic                  out_valid;
  logic                  out_ready;
  logic [CHAN_W-1:0]     out_red;
  logic [CHAN_W-1:0]     out_green;
  logic [CHAN_W-1:0]     out_blue;
  logic [CHAN_W-1:0]     out_alpha;
  logic                  out_consumed;
  logic                  out_row_end;
  logic                  out_frame_end;

  composite_scoreboard board;
  int sender_max_gap     = 10;
  int receiver_max_stall = 10;
  int settings_applied   = 0;
  int corner_idx         = 0;
  bit long_hold_done     = 1'b0;

  letterbox_alpha_compositor_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_red  (in_pixel_red),
    .in_pixel_green(in_pixel_green),
    .in_pixel_blue (in_pixel_blue),
    .in_pixel_alpha(in_pixel_alpha),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .out_consumed  (out_consumed),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: any handshake on any channel restarts the count
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stall before each word, one long hold-off mid-run so the
  // internal queue fills and in_ready drops while words keep being offered
  initial begin : receiver
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && board.words_in >= HOLD_AFTER_WORDS) begin
        stall = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        stall = $urandom_range(0, receiver_max_stall);
      end
      // ready only dropped when a stall is drawn, so back-to-back stays high
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_tick(tick_word_t'({out_red, out_green, out_blue, out_alpha,
                                     out_consumed, out_row_end, out_frame_end}));
    end
  end

  // one register write; valid left high so writes can follow back to back
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_register(index, data);
  endtask

  // all six registers, only once every predicted word has come out
  task automatic apply_setting(input reg_setting_t s, input bit with_spare);
    while (board.pending() != 0) @(posedge clk);
    if (with_spare)
      write_register($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                     CFG_DATA_W'($urandom));
    write_register(REG_TARGET_WIDTH, s.target_width);
    write_register(REG_TARGET_HEIGHT, s.target_height);
    write_register(REG_CONTENT_WIDTH, s.content_width);
    write_register(REG_CONTENT_HEIGHT, s.content_height);
    write_register(REG_BACKGROUND_RGB, s.background_rgb);
    write_register(REG_ALPHA_ENABLE, CFG_DATA_W'(s.alpha_enable));
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // offer one tick after a random gap and hold it until taken
  task automatic drive_tick(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] a);
    int gap;
    gap = $urandom_range(0, sender_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_red   <= r;
    in_pixel_green <= g;
    in_pixel_blue  <= b;
    in_pixel_alpha <= a;
    do @(posedge clk); while (!in_ready);
    board.note_tick(r, g, b, a);
  endtask

  // corner pixels as {red, green, blue, alpha}: transparent, opaque, mid alpha
  function automatic logic [31:0] corner_pixel(int k);
    case (k % 8)
      0:       return 32'h000000FF;
      1:       return 32'hFFFFFF00;
      2:       return 32'hFF00FF80;
      3:       return 32'h00FF007F;
      4:       return 32'h80808001;
      5:       return 32'h7F7F7FFE;
      6:       return 32'hFFFFFFFF;
      default: return 32'h00000000;
    endcase
  endfunction

  // mostly small letterboxed frames so rows and frames wrap often
  function automatic reg_setting_t random_setting();
    reg_setting_t s;
    int tw, th, cw, ch;
    int extremes[4];
    extremes = '{0, 1, MAX_DIM_DEF, 8191};
    tw = $urandom_range(1, 16);
    th = $urandom_range(1, 8);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        cw = $urandom_range(1, tw);
        ch = $urandom_range(1, th);
      end
      6: begin
        // content at least as wide as the target, window clamped to target width
        cw = $urandom_range(tw, tw + 6);
        ch = $urandom_range(1, th);
      end
      7: begin
        // content covers the target both ways: pass-through
        cw = tw + $urandom_range(0, 3);
        ch = th + $urandom_range(0, 3);
      end
      8: begin
        tw = extremes[$urandom_range(0, 3)];
        th = extremes[$urandom_range(0, 3)];
        cw = extremes[$urandom_range(0, 3)];
        ch = extremes[$urandom_range(0, 3)];
      end
      default: begin
        // zero-sized registers read as one
        tw = $urandom_range(0, 1) ? 0 : tw;
        cw = $urandom_range(0, 2);
        ch = $urandom_range(0, 2);
      end
    endcase
    s.target_width   = CFG_DATA_W'(tw);
    s.target_height  = CFG_DATA_W'(th);
    s.content_width  = CFG_DATA_W'(cw);
    s.content_height = CFG_DATA_W'(ch);
    // junk above the 13 register bits now and then
    if ($urandom_range(0, 3) == 0) begin
      s.target_width[CFG_DATA_W-1:CFG_DIM_W]   = 11'($urandom);
      s.target_height[CFG_DATA_W-1:CFG_DIM_W]  = 11'($urandom);
      s.content_width[CFG_DATA_W-1:CFG_DIM_W]  = 11'($urandom);
      s.content_height[CFG_DATA_W-1:CFG_DIM_W] = 11'($urandom);
    end
    case ($urandom_range(0, 3))
      0:       s.background_rgb = 24'h000000;
      1:       s.background_rgb = 24'hFFFFFF;
      default: s.background_rgb = CFG_DATA_W'($urandom);
    endcase
    s.alpha_enable = ($urandom_range(0, 3) != 0);
    return s;
  endfunction

  // one phase: optional register setting, then a run of ticks
  task automatic run_phase(input reg_setting_t s, input bit write_regs, input bit noisy,
                           input bit corners, input int count);
    logic [31:0] px;
    int k;
    if (write_regs) apply_setting(s, noisy);
    // every fourth setting runs flat out on both sides
    if (settings_applied % 4 == 2) begin
      sender_max_gap     = 0;
      receiver_max_stall = 0;
    end else begin
      sender_max_gap     = 10;
      receiver_max_stall = 10;
    end
    for (k = 0; k < count; k++) begin
      if (corners) begin
        px = corner_pixel(corner_idx);
        corner_idx++;
      end else begin
        px = $urandom;
        // fully transparent and fully opaque get extra weight
        case ($urandom_range(0, 7))
          0:       px[7:0] = 8'h00;
          1:       px[7:0] = 8'hFF;
          default: ;
        endcase
      end
      drive_tick(px[31:24], px[23:16], px[15:8], px[7:0]);
    end
    in_valid <= 1'b0;
  endtask

  initial begin : stimulus
    reg_setting_t s;
    int p;
    board = new();
    rst_n          <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_pixel_red   <= '0;
    in_pixel_green <= '0;
    in_pixel_blue  <= '0;
    in_pixel_alpha <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset setting is an 800 square pass-through
    run_phase(s, 1'b0, 1'b0, 1'b1, 3);
    // small letterbox with blending, entered at the new last column
    s = '{24'd4, 24'd3, 24'd2, 24'd1, 24'h00FF80, 1'b1};
    run_phase(s, 1'b1, 1'b0, 1'b1, 10);
    // same window, alpha off: colour copied
    s = '{24'd4, 24'd3, 24'd2, 24'd1, 24'hFF0000, 1'b0};
    run_phase(s, 1'b1, 1'b0, 1'b1, 3);
    // content wider than the target but shorter: padding, clamped window
    s = '{24'd6, 24'd2, 24'd9, 24'd1, 24'h123456, 1'b1};
    run_phase(s, 1'b1, 1'b0, 1'b1, 4);
    // zero sizes read as one: every tick ends the frame
    s = '{24'd0, 24'd0, 24'd0, 24'd0, 24'h000000, 1'b1};
    run_phase(s, 1'b1, 1'b0, 1'b1, 2);
    // oversize registers clamp to the largest frame
    s = '{24'd8191, 24'd8191, 24'd8191, 24'd8191, 24'hFFFFFF, 1'b1};
    run_phase(s, 1'b1, 1'b0, 1'b1, 2);

    // random settings with random pixels
    for (p = 0; p < RANDOM_PHASES; p++) begin
      s = random_setting();
      run_phase(s, 1'b1, 1'b1, 1'b0, WORDS_PER_PHASE);
    end

    // drain, then a few clocks more to catch stray output words
    while (board.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    board.flag_leftovers();
    $display("run covered %0d input words and %0d output words over %0d register settings",
             board.words_in, board.words_out, settings_applied);
    $display("one long output hold-off: %0d cycles, %0d mismatches", LONG_HOLD,
             board.fail_count);
    if (board.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
